// ----- rtl/ssbc_pkg.sv -----
// Shared types and constants for the sample sort bucket classifier.
`timescale 1ns / 1ps

package ssbc_pkg;

  localparam int SCNT_W     = 11;  // sample_count register width
  localparam int PCNT_W     = 7;   // partition_count register width
  localparam int IDX_W      = 10;  // sample_index field width
  localparam int KEY_PORT_W = 64;  // key field width
  localparam int BUCKET_W   = 6;   // bucket field width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_CNT_W  = 4;   // holds SCNT_W

  localparam int MAX_SAMPLES_DEF    = 1024;
  localparam int MAX_PARTITIONS_DEF = 64;
  localparam int KEY_WIDTH_DEF      = 64;

  localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST    = 11'd1024;
  localparam logic [PCNT_W-1:0] PARTITION_COUNT_RST = 7'd64;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 1'b1;

  // Status of the share-size divider.
  typedef struct packed {
    logic              busy;
    logic [SCNT_W-1:0] quot;
    logic [PCNT_W-1:0] rem;
  } div_stat_t;

endpackage

// ----- rtl/ssbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ssbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ssbc_div.sv -----
// Restoring divider that splits the sample count into partition shares.
`timescale 1ns / 1ps

module ssbc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssbc_pkg::SCNT_W-1:0] dividend,
  input  logic [ssbc_pkg::PCNT_W-1:0] divisor,
  output ssbc_pkg::div_stat_t       stat
);

  logic [ssbc_pkg::DIV_CNT_W-1:0] cnt;
  logic [ssbc_pkg::SCNT_W-1:0]    dq;
  logic [ssbc_pkg::PCNT_W-1:0]    rem;
  logic [ssbc_pkg::PCNT_W:0]      trial;
  logic                           fits;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial = {rem, dq[ssbc_pkg::SCNT_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= ssbc_pkg::DIV_CNT_W'(ssbc_pkg::SCNT_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      dq  <= {dq[ssbc_pkg::SCNT_W-2:0], fits};
      rem <= fits ? ssbc_pkg::PCNT_W'(trial - {1'b0, divisor})
                  : trial[ssbc_pkg::PCNT_W-1:0];
    end
  end

  assign stat.busy = start || (cnt != '0);
  assign stat.quot = dq;
  assign stat.rem  = rem;

endmodule

// ----- rtl/ssbc_search.sv -----
// Request sequencer: sample loads and the binary search over partition minimums.
`timescale 1ns / 1ps

module ssbc_search #(
  parameter int MAX_SAMPLES = ssbc_pkg::MAX_SAMPLES_DEF,
  parameter int KEY_WIDTH   = ssbc_pkg::KEY_WIDTH_DEF,
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic [ssbc_pkg::PCNT_W-1:0]   p_eff,
  input  ssbc_pkg::div_stat_t           div_stat,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [ssbc_pkg::IDX_W-1:0]    sample_index,
  input  logic [ssbc_pkg::KEY_PORT_W-1:0] key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssbc_pkg::BUCKET_W-1:0] bucket,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [KEY_WIDTH-1:0]          mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [KEY_WIDTH-1:0]          mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FINISH
  } state_t;

  localparam int PW = ssbc_pkg::PCNT_W;
  localparam int SW = ssbc_pkg::SCNT_W;

  state_t          state;
  logic [PW-1:0]   low;
  logic [PW-1:0]   hi1;   // high bound plus one, so the range is empty when low == hi1
  logic [PW-1:0]   mid;
  logic [PW-1:0]   res;
  logic [KEY_WIDTH-1:0] key_q;

  logic            accept;
  logic            take_ok;
  logic [PW+SW-1:0] prod;
  logic [PW-1:0]   mid_min;
  logic [SW-1:0]   begin_idx;
  logic            ge;
  logic [PW-1:0]   low_next;
  logic [PW-1:0]   hi1_next;
  logic [PW-1:0]   res_next;
  logic [PW:0]     span_sum;
  logic [PW:0]     init_sum;

  assign in_ready = enable && (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign take_ok  = !out_valid || out_ready;

  // Loads go straight into the store; they produce no result.
  assign mem_we    = accept && (req_type == ssbc_pkg::REQ_LOAD) &&
                     (32'(sample_index) < MAX_SAMPLES);
  assign mem_waddr = AW'(sample_index);
  assign mem_wdata = key[KEY_WIDTH-1:0];

  // First sample of share mid: mid * q + min(mid, r).
  assign prod      = {{SW{1'b0}}, mid} * {{PW{1'b0}}, div_stat.quot};
  assign mid_min   = (mid < div_stat.rem) ? mid : div_stat.rem;
  assign begin_idx = prod[SW-1:0] + {{(SW-PW){1'b0}}, mid_min};
  assign mem_re    = (state == S_READ);
  assign mem_raddr = AW'(begin_idx);

  assign ge       = key_q >= mem_rdata;
  assign low_next = ge ? PW'(mid + 1'b1) : low;
  assign hi1_next = ge ? hi1 : mid;
  assign res_next = ge ? mid : res;
  assign span_sum = {1'b0, low_next} + {1'b0, hi1_next} - 1'b1;
  assign init_sum = {1'b0, p_eff} - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && take_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req_type == ssbc_pkg::REQ_CLASSIFY)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= (low_next < hi1_next) ? S_READ : S_FINISH;
        end
        S_FINISH: begin
          if (take_ok) begin
            bucket <= res[ssbc_pkg::BUCKET_W-1:0];
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= key[KEY_WIDTH-1:0];
      low   <= '0;
      hi1   <= p_eff;
      mid   <= init_sum[PW:1];
      res   <= '0;
    end else if (state == S_CMP) begin
      low <= low_next;
      hi1 <= hi1_next;
      mid <= span_sum[PW:1];
      res <= res_next;
    end
  end

endmodule

// ----- rtl/sample_sort_bucket_classifier_unit.sv -----
// Top level of the sample sort bucket classifier.
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_ready) carries one request per transaction.
// A load (req_type 0) writes key into the sample store at sample_index; it
// produces no result. A classify (req_type 1) binary-searches the first
// samples of the partition shares and returns the last partition whose
// first sample is at most the key, on out_valid/out_ready. Each search step
// is one store read followed by one compare.
// The block works on one request at a time. A finished bucket waits in the
// output register; loads are still accepted meanwhile, and a following
// classify holds its result until the receiver takes the previous one.
// After reset and after each configuration write, a share-size divider runs
// with in_ready low. Reset sets sample_count to 1024 and partition_count
// to 64; the store is undefined until loaded.

module sample_sort_bucket_classifier_unit #(
  parameter int MAX_SAMPLES    = ssbc_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_PARTITIONS = ssbc_pkg::MAX_PARTITIONS_DEF,
  parameter int KEY_WIDTH      = ssbc_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [ssbc_pkg::IDX_W-1:0]       sample_index,
  input  logic [ssbc_pkg::KEY_PORT_W-1:0]  key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ssbc_pkg::BUCKET_W-1:0]    bucket
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SW = ssbc_pkg::SCNT_W;
  localparam int PW = ssbc_pkg::PCNT_W;

  logic [SW-1:0] sample_count;
  logic [PW-1:0] partition_count;
  logic          cfg_pending;
  logic          div_start;
  logic [SW-1:0] s_eff;
  logic [PW-1:0] p_sat;
  logic [PW-1:0] p_eff;
  ssbc_pkg::div_stat_t div_stat;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= ssbc_pkg::SAMPLE_COUNT_RST;
      partition_count <= ssbc_pkg::PARTITION_COUNT_RST;
      cfg_pending     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ssbc_pkg::CFG_SAMPLE_COUNT:    sample_count    <= cfg_data;
          ssbc_pkg::CFG_PARTITION_COUNT: partition_count <= cfg_data[PW-1:0];
          default: ;
        endcase
        cfg_pending <= 1'b1;
      end else if (div_start) begin
        cfg_pending <= 1'b0;
      end
    end
  end

  // Clamp both counts; the partition count never exceeds the sample count.
  always_comb begin
    if (sample_count == '0) begin
      s_eff = SW'(1);
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      s_eff = SW'(MAX_SAMPLES);
    end else begin
      s_eff = sample_count;
    end
    if (partition_count == '0) begin
      p_sat = PW'(1);
    end else if (32'(partition_count) > MAX_PARTITIONS) begin
      p_sat = PW'(MAX_PARTITIONS);
    end else begin
      p_sat = partition_count;
    end
    p_eff = ({{(SW-PW){1'b0}}, p_sat} > s_eff) ? s_eff[PW-1:0] : p_sat;
  end

  assign div_start = cfg_pending && !cfg_we;

  ssbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_eff),
    .divisor  (p_eff),
    .stat     (div_stat)
  );

  ssbc_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssbc_search #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .enable       (!cfg_pending && !div_stat.busy),
    .p_eff        (p_eff),
    .div_stat     (div_stat),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample_index (sample_index),
    .key          (key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket       (bucket),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // No request may start while the share sizes are being recomputed.
  a_no_accept_while_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !in_ready)
    else $error("request accepted while divider busy");

  // The store is only written by a load transaction.
  a_write_only_on_load: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (in_valid && in_ready && (req_type == ssbc_pkg::REQ_LOAD)))
    else $error("store written outside a load transaction");

  // A store read never coincides with a load.
  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> !mem_we)
    else $error("store read and write in the same cycle");

endmodule
